[sv/ocwp_pkg.sv]
// Package for the omnidirectional camera world projection block.
// Holds sizes, codes, the arctangent table, pipeline payload types and fixed-point helpers.
// No dependencies.
`timescale 1ns / 1ps

package ocwp_pkg;

	localparam int MAX_TERMS    = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int ROOT_STEPS   = 32;
	localparam int DIV_STEPS    = 31;
	localparam int GEO_STEPS    = (CORDIC_STEPS > DIV_STEPS) ? CORDIC_STEPS : DIV_STEPS;
	localparam int HRN_STEPS    = MAX_TERMS - 1;
	localparam int TAW          = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW           = 52;
	localparam int COEF_W       = 48;
	localparam int IN_W         = 152;
	localparam int OUT_W        = 64;

	typedef enum logic {
		OP_COEF  = 1'b0,
		OP_POINT = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		REG_CENTER_ROW = 3'd0,
		REG_CENTER_COL = 3'd1,
		REG_AFFINE_C   = 3'd2,
		REG_AFFINE_D   = 3'd3,
		REG_AFFINE_E   = 3'd4,
		REG_POLY_TERMS = 3'd5
	} reg_idx_t;

	localparam logic signed [31:0] ATAN_Q30 [32] = '{
		32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158, 32'sd67021686,
		32'sd33543515, 32'sd16775850, 32'sd8388437, 32'sd4194282, 32'sd2097149,
		32'sd1048575, 32'sd524287, 32'sd262143, 32'sd131071, 32'sd65535, 32'sd32767,
		32'sd16383, 32'sd8191, 32'sd4095, 32'sd2047, 32'sd1023, 32'sd511, 32'sd255,
		32'sd127, 32'sd63, 32'sd31, 32'sd15, 32'sd7, 32'sd3, 32'sd1, 32'sd0, 32'sd0
	};

	typedef struct packed {
		logic                     valid;
		logic                     point;
		logic                     on_axis;
		logic                     x_neg;
		logic                     y_neg;
		logic [3:0]               idx;
		logic signed [COEF_W-1:0] coef;
	} tag_t;

	typedef struct packed {
		tag_t               tag;
		logic signed [31:0] z;
		logic [31:0]        xm;
		logic [31:0]        ym;
	} in_t;

	typedef struct packed {
		tag_t               tag;
		logic signed [31:0] z;
		logic [31:0]        xm;
		logic [31:0]        ym;
		logic [63:0]        xsq;
		logic [63:0]        ysq;
	} sq_t;

	typedef struct packed {
		tag_t               tag;
		logic signed [31:0] z;
		logic [31:0]        xm;
		logic [31:0]        ym;
		logic [63:0]        v;
		logic [63:0]        r;
	} rt_t;

	typedef struct packed {
		tag_t               tag;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [31:0] ang;
		logic [31:0]        norm;
		logic [62:0]        remx;
		logic [62:0]        remy;
		logic [30:0]        qx;
		logic [30:0]        qy;
	} geo_t;

	typedef struct packed {
		logic        neg;
		logic [56:0] hi;
		logic [55:0] lo;
	} mul_part_t;

	typedef struct packed {
		tag_t                     tag;
		logic signed [31:0]       ang;
		logic signed [31:0]       rx;
		logic signed [31:0]       ry;
		logic signed [COEF_W-1:0] rho;
		mul_part_t                part;
	} hrn_t;

	typedef struct packed {
		tag_t      tag;
		mul_part_t pxp;
		mul_part_t pyp;
	} rat_t;

	typedef struct packed {
		tag_t               tag;
		logic signed [48:0] px;
		logic signed [48:0] py;
	} pq_t;

	typedef struct packed {
		tag_t               tag;
		mul_part_t          pc;
		mul_part_t          pd;
		mul_part_t          pe;
		logic signed [48:0] py;
	} aff_t;

	typedef struct packed {
		tag_t               tag;
		logic signed [49:0] mc;
		logic signed [49:0] md;
		logic signed [49:0] me;
		logic signed [49:0] mf;
	} term_t;

	typedef struct packed {
		logic               valid;
		logic               point;
		logic               on_axis;
		logic signed [31:0] row;
		logic signed [31:0] col;
	} out_t;

	// First half of a sign-magnitude product: a 25x32 and a 24x32 partial product.
	function automatic mul_part_t mul_split(input logic signed [48:0] a,
			input logic signed [31:0] b);
		logic [48:0] ua;
		logic [31:0] ub;
		mul_part_t   p;
		ua = a[48] ? 49'(-a) : 49'(a);
		ub = b[31] ? 32'(-b) : 32'(b);
		p.neg = a[48] ^ b[31];
		p.hi  = ua[48:24] * ub;
		p.lo  = ua[23:0] * ub;
		return p;
	endfunction

	// Second half: combine, shift right by sh and apply the sign (truncation toward zero).
	function automatic logic signed [58:0] mul_join(input mul_part_t p, input int sh);
		logic [57:0] s;
		logic [57:0] r;
		s = 58'(p.hi) + 58'(p.lo[55:24]);
		r = s >> (sh - 24);
		return p.neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

	function automatic logic signed [COEF_W-1:0] sat48(input logic signed [59:0] v);
		logic signed [59:0] hi;
		logic signed [59:0] lo;
		hi = (60'sd1 <<< (COEF_W - 1)) - 60'sd1;
		lo = -hi - 60'sd1;
		if (v > hi) begin
			return hi[COEF_W-1:0];
		end else if (v < lo) begin
			return lo[COEF_W-1:0];
		end
		return v[COEF_W-1:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		if (v > 52'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -52'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

[sv/ocwp_geom.sv]
// Geometry front end: planar norm by a pipelined square root, then CORDIC angle and
// the two axis ratios by pipelined restoring division, one step per stage.
// Depends on ocwp_pkg.
`timescale 1ns / 1ps

module ocwp_geom import ocwp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  in_t  in_s1,
	output geo_t geo_out
);

	sq_t  sq_s2;
	rt_t  sum_s3;
	rt_t  root_sn [ROOT_STEPS];
	rt_t  root_in [ROOT_STEPS];
	rt_t  root_d  [ROOT_STEPS];
	geo_t geo_sn  [GEO_STEPS];
	geo_t geo_in  [GEO_STEPS];
	geo_t geo_d   [GEO_STEPS];
	geo_t geo_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_s2 <= '0;
		end else if (adv) begin
			sq_s2.tag <= in_s1.tag;
			sq_s2.z   <= in_s1.z;
			sq_s2.xm  <= in_s1.xm;
			sq_s2.ym  <= in_s1.ym;
			sq_s2.xsq <= in_s1.xm * in_s1.xm;
			sq_s2.ysq <= in_s1.ym * in_s1.ym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_s3 <= '0;
		end else if (adv) begin
			sum_s3.tag <= sq_s2.tag;
			sum_s3.z   <= sq_s2.z;
			sum_s3.xm  <= sq_s2.xm;
			sum_s3.ym  <= sq_s2.ym;
			sum_s3.v   <= sq_s2.xsq + sq_s2.ysq;
			sum_s3.r   <= '0;
		end
	end

	// Bit-by-bit integer square root, one result bit per stage.
	for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		if (i == 0) begin : g_first
			assign root_in[i] = sum_s3;
		end else begin : g_next
			assign root_in[i] = root_sn[i-1];
		end

		always_comb begin
			logic [63:0] t;
			t = root_in[i].r + BIT;
			root_d[i] = root_in[i];
			if (root_in[i].v >= t) begin
				root_d[i].v = root_in[i].v - t;
				root_d[i].r = (root_in[i].r >> 1) + BIT;
			end else begin
				root_d[i].r = root_in[i].r >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				root_sn[i] <= '0;
			end else if (adv) begin
				root_sn[i] <= root_d[i];
			end
		end
	end

	always_comb begin
		geo_entry.tag  = root_sn[ROOT_STEPS-1].tag;
		geo_entry.norm = root_sn[ROOT_STEPS-1].r[31:0];
		geo_entry.cx   = $signed({(CW - 32)'(0), root_sn[ROOT_STEPS-1].r[31:0]}) <<< 16;
		geo_entry.cy   = CW'(root_sn[ROOT_STEPS-1].z) <<< 16;
		geo_entry.ang  = '0;
		geo_entry.remx = {1'b0, root_sn[ROOT_STEPS-1].xm, 30'd0};
		geo_entry.remy = {1'b0, root_sn[ROOT_STEPS-1].ym, 30'd0};
		geo_entry.qx   = '0;
		geo_entry.qy   = '0;
	end

	// CORDIC vectoring (first CORDIC_STEPS stages) and the two quotient digits (first DIV_STEPS) share each stage.
	for (genvar j = 0; j < GEO_STEPS; j++) begin : g_geo
		localparam int B = (j < DIV_STEPS) ? (DIV_STEPS - 1 - j) : 0;
		localparam int A = j % 32;
		if (j == 0) begin : g_first
			assign geo_in[j] = geo_entry;
		end else begin : g_next
			assign geo_in[j] = geo_sn[j-1];
		end

		always_comb begin
			logic signed [CW-1:0] dx;
			logic signed [CW-1:0] dy;
			logic [62:0]          dv;
			geo_d[j] = geo_in[j];
			dx = geo_in[j].cy >>> A;
			dy = geo_in[j].cx >>> A;
			dv = {31'd0, geo_in[j].norm} << B;
			if (j < CORDIC_STEPS) begin
				if (!geo_in[j].cy[CW-1]) begin
					geo_d[j].cx  = geo_in[j].cx + dx;
					geo_d[j].cy  = geo_in[j].cy - dy;
					geo_d[j].ang = geo_in[j].ang + ATAN_Q30[A];
				end else begin
					geo_d[j].cx  = geo_in[j].cx - dx;
					geo_d[j].cy  = geo_in[j].cy + dy;
					geo_d[j].ang = geo_in[j].ang - ATAN_Q30[A];
				end
			end
			if (j < DIV_STEPS) begin
				if (geo_in[j].remx >= dv) begin
					geo_d[j].remx = geo_in[j].remx - dv;
					geo_d[j].qx   = {geo_in[j].qx[29:0], 1'b1};
				end else begin
					geo_d[j].qx   = {geo_in[j].qx[29:0], 1'b0};
				end
				if (geo_in[j].remy >= dv) begin
					geo_d[j].remy = geo_in[j].remy - dv;
					geo_d[j].qy   = {geo_in[j].qy[29:0], 1'b1};
				end else begin
					geo_d[j].qy   = {geo_in[j].qy[29:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				geo_sn[j] <= '0;
			end else if (adv) begin
				geo_sn[j] <= geo_d[j];
			end
		end
	end

	assign geo_out = geo_sn[GEO_STEPS-1];

endmodule

[sv/omni_camera_world_projection.sv]
// Top level of the omnidirectional camera world projection block.
// Holds configuration, coefficient copies, the Horner pipeline and the affine output stages.
// Depends on ocwp_pkg and ocwp_geom.
`timescale 1ns / 1ps

// Usage:
// Beats on the s_ channel either write one polynomial coefficient (s_tuser = 0) or carry a
// world point to project (s_tuser = 1). Each point beat yields one beat on the m_ channel;
// coefficient beats yield none, but travel down the pipeline in order and update the
// coefficient copies held at each Horner stage, so a write affects exactly the points
// that follow it.
// The cfg_ channel writes the centre, affine terms and term count; it is always ready
// and must only be used while no point is in flight.
// The datapath is one stall-together pipeline: a beat may enter every cycle while it is not
// stalled. The 32-stage square root, the 31-stage ratio division and the two stages per
// Horner step account for most of its depth.
// When the receiver holds m_tready low with a result waiting, the whole pipeline and
// s_tready stall; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults (affine_c one, one term).
// Coefficient entries are undefined until written.

module omni_camera_world_projection import ocwp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// coef_index[3:0], coef_value[51:4], point_x[83:52], point_y[115:84], point_z[147:116]
	input  logic [IN_W-1:0]   s_tdata,
	// op[0]
	input  logic [0:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// image_row[31:0], image_col[63:32]
	output logic [OUT_W-1:0]  m_tdata,
	// on_axis[0]
	output logic [0:0]        m_tuser,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	logic signed [31:0] center_row_q;
	logic signed [31:0] center_col_q;
	logic signed [31:0] affine_c_q;
	logic signed [31:0] affine_d_q;
	logic signed [31:0] affine_e_q;
	logic [4:0]         poly_terms_q;

	logic adv;
	logic [TAW-1:0] nm1;

	in_t   in_s1;
	in_t   in_d;
	geo_t  geo_out;
	hrn_t  hin_sn;
	hrn_t  hin_d;
	hrn_t  hmul_sn [HRN_STEPS];
	hrn_t  hacc_sn [HRN_STEPS];
	hrn_t  hmul_in [HRN_STEPS];
	hrn_t  hmul_d  [HRN_STEPS];
	hrn_t  hacc_d  [HRN_STEPS];
	rat_t  rat_sn;
	pq_t   pq_sn;
	aff_t  aff_sn;
	term_t term_sn;
	out_t  out_sn;

	logic signed [COEF_W-1:0] tbl_q       [MAX_TERMS];
	logic signed [COEF_W-1:0] step_coef_q [HRN_STEPS];

	assign cfg_ready = 1'b1;
	assign adv       = !m_tvalid || m_tready;
	assign s_tready  = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_row_q <= '0;
			center_col_q <= '0;
			affine_c_q   <= 32'sd16777216;
			affine_d_q   <= '0;
			affine_e_q   <= '0;
			poly_terms_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CENTER_ROW: center_row_q <= cfg_data;
				REG_CENTER_COL: center_col_q <= cfg_data;
				REG_AFFINE_C:   affine_c_q   <= cfg_data;
				REG_AFFINE_D:   affine_d_q   <= cfg_data;
				REG_AFFINE_E:   affine_e_q   <= cfg_data;
				REG_POLY_TERMS: poly_terms_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Highest coefficient index in use; zero terms act as one, too many as MAX_TERMS.
	always_comb begin
		if (poly_terms_q == 5'd0) begin
			nm1 = '0;
		end else if (int'(poly_terms_q) > MAX_TERMS) begin
			nm1 = TAW'(MAX_TERMS - 1);
		end else begin
			nm1 = TAW'(poly_terms_q - 5'd1);
		end
	end

	always_comb begin
		logic signed [31:0] x;
		logic signed [31:0] y;
		x = s_tdata[83:52];
		y = s_tdata[115:84];
		in_d.tag.valid   = s_tvalid;
		in_d.tag.point   = (s_tuser[0] == OP_POINT);
		in_d.tag.on_axis = (x == 32'sd0) && (y == 32'sd0);
		in_d.tag.x_neg   = x[31];
		in_d.tag.y_neg   = y[31];
		in_d.tag.idx     = s_tdata[3:0];
		in_d.tag.coef    = s_tdata[51:4];
		in_d.z           = s_tdata[147:116];
		in_d.xm          = x[31] ? 32'(-x) : 32'(x);
		in_d.ym          = y[31] ? 32'(-y) : 32'(y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_s1 <= '0;
		end else if (adv) begin
			in_s1 <= in_d;
		end
	end

	ocwp_geom u_geom (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_s1   (in_s1),
		.geo_out (geo_out)
	);

	// Full coefficient copy used to seed the Horner accumulator.
	always_ff @(posedge clk) begin
		if (adv && geo_out.tag.valid && !geo_out.tag.point
				&& (int'(geo_out.tag.idx) < MAX_TERMS)) begin
			tbl_q[TAW'(geo_out.tag.idx)] <= geo_out.tag.coef;
		end
	end

	always_comb begin
		hin_d.tag  = geo_out.tag;
		hin_d.ang  = geo_out.ang;
		hin_d.rx   = geo_out.tag.x_neg ? -$signed({1'b0, geo_out.qx})
		                               : $signed({1'b0, geo_out.qx});
		hin_d.ry   = geo_out.tag.y_neg ? -$signed({1'b0, geo_out.qy})
		                               : $signed({1'b0, geo_out.qy});
		hin_d.rho  = tbl_q[nm1];
		hin_d.part = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hin_sn <= '0;
		end else if (adv) begin
			hin_sn <= hin_d;
		end
	end

	// Horner steps for k = MAX_TERMS-1 down to 1: a product stage, then an add stage.
	for (genvar t = 0; t < HRN_STEPS; t++) begin : g_hrn
		localparam int K = MAX_TERMS - 1 - t;
		if (t == 0) begin : g_first
			assign hmul_in[t] = hin_sn;
		end else begin : g_next
			assign hmul_in[t] = hacc_sn[t-1];
		end

		always_comb begin
			hmul_d[t]      = hmul_in[t];
			hmul_d[t].part = mul_split(49'(hmul_in[t].rho), hmul_in[t].ang);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hmul_sn[t] <= '0;
			end else if (adv) begin
				hmul_sn[t] <= hmul_d[t];
			end
		end

		// This stage's own copy of coefficient K-1, updated as write beats pass by.
		always_ff @(posedge clk) begin
			if (adv && hmul_sn[t].tag.valid && !hmul_sn[t].tag.point
					&& (int'(hmul_sn[t].tag.idx) == K - 1)) begin
				step_coef_q[t] <= hmul_sn[t].tag.coef;
			end
		end

		always_comb begin
			hacc_d[t] = hmul_sn[t];
			if (int'(nm1) >= K) begin
				hacc_d[t].rho = sat48(60'(mul_join(hmul_sn[t].part, 30))
				                      + 60'(step_coef_q[t]));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hacc_sn[t] <= '0;
			end else if (adv) begin
				hacc_sn[t] <= hacc_d[t];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rat_sn  <= '0;
			pq_sn   <= '0;
			aff_sn  <= '0;
			term_sn <= '0;
			out_sn  <= '0;
		end else if (adv) begin
			rat_sn.tag <= hacc_sn[HRN_STEPS-1].tag;
			rat_sn.pxp <= mul_split(49'(hacc_sn[HRN_STEPS-1].rho), hacc_sn[HRN_STEPS-1].rx);
			rat_sn.pyp <= mul_split(49'(hacc_sn[HRN_STEPS-1].rho), hacc_sn[HRN_STEPS-1].ry);

			pq_sn.tag <= rat_sn.tag;
			pq_sn.px  <= 49'(mul_join(rat_sn.pxp, 30));
			pq_sn.py  <= 49'(mul_join(rat_sn.pyp, 30));

			aff_sn.tag <= pq_sn.tag;
			aff_sn.pc  <= mul_split(pq_sn.px, affine_c_q);
			aff_sn.pd  <= mul_split(pq_sn.py, affine_d_q);
			aff_sn.pe  <= mul_split(pq_sn.px, affine_e_q);
			aff_sn.py  <= pq_sn.py;

			// The unit affine term reduces to py / 256 truncated toward zero.
			term_sn.tag <= aff_sn.tag;
			term_sn.mc  <= 50'(mul_join(aff_sn.pc, 32));
			term_sn.md  <= 50'(mul_join(aff_sn.pd, 32));
			term_sn.me  <= 50'(mul_join(aff_sn.pe, 32));
			term_sn.mf  <= aff_sn.py[48] ? -50'((-aff_sn.py) >>> 8) : 50'(aff_sn.py >>> 8);

			out_sn.valid   <= term_sn.tag.valid;
			out_sn.point   <= term_sn.tag.point;
			out_sn.on_axis <= term_sn.tag.on_axis;
			if (term_sn.tag.on_axis) begin
				out_sn.row <= center_row_q;
				out_sn.col <= center_col_q;
			end else begin
				out_sn.row <= sat32(52'(term_sn.mc) + 52'(term_sn.md) + 52'(center_row_q));
				out_sn.col <= sat32(52'(term_sn.me) + 52'(term_sn.mf) + 52'(center_col_q));
			end
		end
	end

	assign m_tvalid = out_sn.valid && out_sn.point;
	assign m_tdata  = {out_sn.col, out_sn.row};
	assign m_tuser  = out_sn.on_axis;

endmodule
